>>> sv/ordered_id_set_table_top_assert.svh
// ----------------------------------------------------------------------------
// Ordered id set table assertion macros
// Shorthand for clocked assertions that are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ID_SET_TABLE_TOP_ASSERT_SVH
`define ORDERED_ID_SET_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OIDT_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OIDT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

>>> sv/oidt_pkg.sv
// ----------------------------------------------------------------------------
// Ordered id set table package
// Command and status codes, fixed field widths and the cell control bundle.
// ----------------------------------------------------------------------------
package oidt_pkg;

    localparam int unsigned OIDT_MAX_ENTRIES = 64;

    localparam int unsigned ID_W     = 8;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned FIELD_W  = 7;
    // Wide enough for any count up to the largest table of 256 entries.
    localparam int unsigned WIDE_W   = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_GET    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_RANGE  = 3'd2,
        ST_DUP    = 3'd3,
        ST_ABSENT = 3'd4
    } status_t;

    typedef struct packed {
        logic              load;     // compare the operand against every entry
        logic [ID_W-1:0]   operand;
        logic              add_en;   // append operand at position count
        logic              rem_en;   // close the gap at position pos
        logic [ID_W-1:0]   pos;
        logic [WIDE_W-1:0] count;
    } cell_ctl_t;

endpackage

>>> sv/oidt_cell.sv
// ----------------------------------------------------------------------------
// Ordered id set table cell
// Holds one list entry, compares it with the operand and takes its right
// neighbour's entry when a removal closes the gap.
// ----------------------------------------------------------------------------
module oidt_cell
    import oidt_pkg::*;
#(
    parameter int unsigned IDX = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  cell_ctl_t       ctl,
    input  logic [ID_W-1:0] right_id,
    output logic [ID_W-1:0] id,
    output logic            match,
    output logic [ID_W-1:0] sel_id,
    output logic            sel
);

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;
    logic            match_reg;
    logic            sel_reg;
    logic            valid;
    logic            at_tail;
    logic            in_gap;

    assign valid   = WIDE_W'(IDX) < ctl.count;
    assign at_tail = WIDE_W'(IDX) == ctl.count;
    // Entries from the removed position up to the one before last move down.
    assign in_gap  = (WIDE_W'(IDX) >= {1'b0, ctl.pos}) && (WIDE_W'(IDX + 1) < ctl.count);

    always_comb
    begin
        id_next = id_reg;
        if (ctl.add_en && at_tail)
        begin
            id_next = ctl.operand;
        end
        else if (ctl.rem_en && in_gap)
        begin
            id_next = right_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else if (ctl.load)
        begin
            match_reg <= valid && (id_reg == ctl.operand);
            sel_reg   <= valid && (ctl.operand == ID_W'(IDX));
        end
    end

    assign id     = id_reg;
    assign match  = match_reg;
    assign sel    = sel_reg;
    assign sel_id = sel_reg ? id_reg : '0;

endmodule

>>> sv/ordered_id_set_table_top.sv
// ----------------------------------------------------------------------------
// Ordered id set table
// Duplicate-free list of member ids in insertion order, held in a row of
// cells, with add, remove, find and get commands.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Contents
//  s_*       in         tvalid / tready    command, operand
//  m_*       out        tvalid / tready    status, answer, member_count
//  cfg_*     in         write enable only  capacity
//
//  Every cell compares its entry with the operand on the accepting edge, and
//  the resolving edge in S_EXEC resolves the command, shifts the cells on a
//  removal and loads the output register.
//  The resolving cycle waits while the output register holds an untaken result.
//  After reset the list is empty and the capacity is zero.
// ----------------------------------------------------------------------------
module ordered_id_set_table_top
    import oidt_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = OIDT_MAX_ENTRIES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // command[1:0], operand[9:2]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // status[2:0], answer[9:3], member_count[16:10]
    input  logic                cfg_we,
    input  logic [FIELD_W-1:0]  cfg_wdata
);

    localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [FIELD_W-1:0]  cap_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    cmd_t                cmd_reg;
    logic [ID_W-1:0]     opnd_reg;
    logic                m_valid_reg;
    logic [23:0]         m_data_reg;

    logic                accept;
    logic                exec_go;
    cell_ctl_t           ctl;
    logic [ID_W-1:0]     id_vec  [MAX_ENTRIES];
    logic [ID_W-1:0]     sid_vec [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] sel_vec;

    logic [IDX_W-1:0]    pos;
    logic [ID_W-1:0]     got_id;
    logic                find_hit;
    logic                get_hit;
    logic [WIDE_W-1:0]   cnt_wide;
    logic [WIDE_W-1:0]   eff_cap;
    status_t             status;
    logic [FIELD_W-1:0]  answer;
    logic [FIELD_W-1:0]  count_field;
    logic                add_en;
    logic                rem_en;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign exec_go  = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);

    // ------------------------------------------------------------------
    // Row of cells
    // ------------------------------------------------------------------
    assign ctl.load    = accept;
    assign ctl.operand = accept ? s_tdata[9:2] : opnd_reg;
    assign ctl.add_en  = exec_go && add_en;
    assign ctl.rem_en  = exec_go && rem_en;
    assign ctl.pos     = ID_W'(pos);
    assign ctl.count   = cnt_wide;

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        logic [ID_W-1:0] right_id;
        if (g == MAX_ENTRIES - 1)
        begin : g_last
            assign right_id = id_vec[g];
        end
        else
        begin : g_mid
            assign right_id = id_vec[g+1];
        end

        oidt_cell #(
            .IDX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .right_id (right_id),
            .id       (id_vec[g]),
            .match    (match_vec[g]),
            .sel_id   (sid_vec[g]),
            .sel      (sel_vec[g])
        );
    end

    // Ids are unique, so at most one cell matches and an OR of the
    // cell indexes gives its position.
    always_comb
    begin
        pos    = '0;
        got_id = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                pos = pos | IDX_W'(i);
            end
            got_id = got_id | sid_vec[i];
        end
    end

    assign find_hit = |match_vec;
    assign get_hit  = |sel_vec;
    assign cnt_wide = WIDE_W'(count_reg);
    assign eff_cap  = ({2'b00, cap_reg} > WIDE_W'(MAX_ENTRIES)) ?
                      WIDE_W'(MAX_ENTRIES) : {2'b00, cap_reg};

    // ------------------------------------------------------------------
    // Command resolution
    // ------------------------------------------------------------------
    always_comb
    begin
        status     = ST_OK;
        answer     = '0;
        add_en     = 1'b0;
        rem_en     = 1'b0;
        count_next = count_reg;
        case (cmd_reg)
            CMD_ADD:
            begin
                if (cnt_wide >= eff_cap)
                begin
                    status = ST_FULL;
                end
                else if ({1'b0, opnd_reg} >= eff_cap)
                begin
                    status = ST_RANGE;
                end
                else if (find_hit)
                begin
                    status = ST_DUP;
                end
                else
                begin
                    add_en     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    answer     = FIELD_W'(WIDE_W'(count_next));
                end
            end
            CMD_REMOVE:
            begin
                if (find_hit)
                begin
                    rem_en     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status = ST_ABSENT;
                end
            end
            CMD_FIND:
            begin
                if (find_hit)
                begin
                    answer = FIELD_W'(WIDE_W'(pos));
                end
                else
                begin
                    status = ST_ABSENT;
                end
            end
            default:
            begin
                if (get_hit)
                begin
                    answer = got_id[FIELD_W-1:0];
                end
                else
                begin
                    status = ST_ABSENT;
                end
            end
        endcase
    end

    assign count_field = FIELD_W'(count_next);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cap_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (exec_go)
            begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_t'(s_tdata[1:0]);
            opnd_reg <= s_tdata[9:2];
        end
        if (exec_go)
        begin
            m_data_reg <= {7'd0, count_field, answer, status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> sv/oidt_checker.sv
// ----------------------------------------------------------------------------
// Ordered id set table port checker
// Watches the top level's ports and flags results that break the contract.
// ----------------------------------------------------------------------------
`include "ordered_id_set_table_top_assert.svh"

module oidt_checker
    import oidt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [23:0]         m_tdata
);

    logic in_txn;
    logic out_stall;

    assign in_txn    = s_tvalid && s_tready;
    assign out_stall = m_tvalid && !m_tready;

    // A result waiting to be taken keeps its value.
    `OIDT_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata))

    // A command is resolved before the next one is taken.
    `OIDT_ASSERT_NEXT(a_one_in_flight, in_txn, !s_tready)

    // Only the five defined status codes appear.
    `OIDT_ASSERT_SAME(a_status_code, m_tvalid, m_tdata[2:0] <= ST_ABSENT)

    // A refused command carries no answer.
    `OIDT_ASSERT_SAME(a_refused_no_answer, m_tvalid && (m_tdata[2:0] != ST_OK), m_tdata[9:3] == 7'd0)

endmodule

bind ordered_id_set_table_top oidt_checker u_oidt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
